@@ rtl/core/sft_pkg.sv @@
// shared types and constants of the stepwise frequency throttle
package sft_pkg;

  localparam int FREQ_W = 24;
  localparam int CNT_W  = 8;

  // opcodes of an input item
  localparam logic [1:0] OP_WARN     = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_LOAD_CPU = 2'd2;
  localparam logic [1:0] OP_LOAD_GPU = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOINIT  = 2'd1;
  localparam logic [1:0] ST_LOADED  = 2'd2;

  // destination code of the gpu
  localparam logic [2:0] GPU_DEST = 3'd4;

  // saturation value of the step counter
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_SKIP_MASK = 3'd1;
  localparam logic [2:0] REG_TOP_LVLS  = 3'd2;
  localparam logic [2:0] REG_GPU_ENTS  = 3'd3;
  localparam logic [2:0] REG_GPU_REL   = 3'd4;

  // input item
  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        cluster_index;
    logic [4:0]        entry_index;
    logic [FREQ_W-1:0] entry_freq;
  } sft_item_t;

  // result item
  typedef struct packed {
    logic [2:0]        destination;
    logic [FREQ_W-1:0] new_limit;
    logic              update;
    logic [CNT_W-1:0]  step_count;
    logic [1:0]        status;
    logic              last;
  } sft_result_t;

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CSEL  = 11'b000_0000_0010,
    S_HALF  = 11'b000_0000_0100,
    S_SCAN  = 11'b000_0000_1000,
    S_ADD   = 11'b000_0001_0000,
    S_CEMIT = 11'b000_0010_0000,
    S_GPU   = 11'b000_0100_0000,
    S_GEMIT = 11'b000_1000_0000,
    S_RREAD = 11'b001_0000_0000,
    S_REMIT = 11'b010_0000_0000,
    S_RGPU  = 11'b100_0000_0000
  } sft_state_e;

endpackage

@@ rtl/core/stepwise_frequency_throttle_unit.sv @@
// stepwise frequency throttle: table memories, level search sequencer, apb registers
//
//  channel  | direction | signals                      | handshake
//  ---------+-----------+------------------------------+------------------------------
//  command  | in        | start, busy, item_i          | taken when start && !busy
//  result   | out       | res_valid_o, res_o           | one cycle per item, no stall
//  config   | in/out    | psel..pwdata, prdata, pready | apb write, pready tied high
//
// table loads, disabled events and a release with a zero counter answer with one
// item in the cycle after the command; busy stays low.
// a warning passes each masked cluster through S_CSEL and each active cluster through
// S_CSEL, S_HALF, S_SCAN (skipped at top level 0), S_ADD and S_CEMIT, then the gpu
// through S_GPU and S_GEMIT. a release passes S_RREAD and S_REMIT per cluster, then
// S_RGPU. the cluster table memory has a single read port.
// reset clears the counter and the cluster levels and sets the registers to their defaults;
// the tables are not cleared and hold unknown data until loaded. results cannot be held off.
module stepwise_frequency_throttle_unit #(
  parameter int NUM_CLUSTERS   = 4,
  parameter int CLUSTER_LEVELS = 32,
  parameter int GPU_LEVELS     = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start,
  output logic                busy,
  input  sft_pkg::sft_item_t  item_i,
  // result channel
  output logic                res_valid_o,
  output sft_pkg::sft_result_t res_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LVL_W  = $clog2(CLUSTER_LEVELS);
  localparam int SCN_W  = $clog2(CLUSTER_LEVELS + 1);
  localparam int SUM_W  = SCN_W + sft_pkg::CNT_W;
  localparam int CW     = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int CDEPTH = NUM_CLUSTERS * CLUSTER_LEVELS;
  localparam int CA_W   = $clog2(CDEPTH);
  localparam int GA_W   = $clog2(GPU_LEVELS);
  localparam int GE_W   = $clog2(GPU_LEVELS + 1);
  localparam int GI_W   = sft_pkg::CNT_W + 1;
  localparam int FW     = sft_pkg::FREQ_W;

  // configuration registers
  logic           enable_q;
  logic [3:0]     skip_q;
  logic [19:0]    tops_q;
  logic [5:0]     gents_q;
  logic [FW-1:0]  grel_q;

  // control state
  sft_pkg::sft_state_e        state_q, state_d;
  logic [sft_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]              c_q, c_d;
  logic [SCN_W-1:0]           lvl_q, lvl_d;
  logic [FW-1:0]              half_q, half_d;
  logic [LVL_W-1:0]           fin_q, fin_d;
  logic                       gok_q, gok_d;
  logic [LVL_W-1:0]           level_q [NUM_CLUSTERS];
  logic [LVL_W-1:0]           level_d [NUM_CLUSTERS];
  logic                       res_valid_q, res_valid_d;
  sft_pkg::sft_result_t       res_q, res_d;

  // table memories
  logic [FW-1:0]   cmem_q [CDEPTH];
  logic [FW-1:0]   gmem_q [GPU_LEVELS];
  logic [FW-1:0]   c_rdata_q, g_rdata_q;
  logic [CA_W-1:0] c_raddr, c_waddr;
  logic [GA_W-1:0] g_raddr;
  logic            c_we, g_we;

  // helper values
  logic                 accept;
  logic                 cfg_we;
  logic [4:0]           top_raw;
  logic [LVL_W-1:0]     top_lvl;
  logic                 c_last;
  logic [SUM_W-1:0]     sum;
  logic [LVL_W-1:0]     fin;
  logic [GE_W-1:0]      gents;
  logic [GI_W-1:0]      gidx;

  function automatic logic [CA_W-1:0] caddr(input logic [CW-1:0] c,
                                            input logic [LVL_W-1:0] l);
    return CA_W'(int'(c) * CLUSTER_LEVELS + int'(l));
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q != sft_pkg::S_IDLE);
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // top level of the current cluster, clamped to the table depth
  assign top_raw = tops_q[5*c_q +: 5];
  assign top_lvl = (top_raw > 5'(CLUSTER_LEVELS - 1)) ? LVL_W'(CLUSTER_LEVELS - 1)
                                                      : top_raw[LVL_W-1:0];
  assign c_last  = (c_q == CW'(NUM_CLUSTERS - 1));

  // search result plus step count, clamped to top
  assign sum = SUM_W'(lvl_q) + SUM_W'(cnt_q);
  assign fin = (sum > SUM_W'(top_lvl)) ? top_lvl : sum[LVL_W-1:0];

  // gpu index from the clamped entry count
  assign gents = (gents_q > 6'(GPU_LEVELS)) ? GE_W'(GPU_LEVELS) : gents_q[GE_W-1:0];
  assign gidx  = GI_W'(gents >> 1) + GI_W'(cnt_q);

  // cluster table read address per state
  always_comb begin
    case (state_q)
      sft_pkg::S_HALF:  c_raddr = caddr(c_q, lvl_q[LVL_W-1:0]);
      sft_pkg::S_SCAN:  c_raddr = caddr(c_q, LVL_W'(lvl_q + SCN_W'(1)));
      sft_pkg::S_ADD:   c_raddr = caddr(c_q, fin);
      default:          c_raddr = caddr(c_q, '0);
    endcase
  end

  assign g_raddr = gidx[GA_W-1:0];

  // table loads from the command channel
  assign c_we    = accept && (item_i.opcode == sft_pkg::OP_LOAD_CPU)
                   && (3'(item_i.cluster_index) < 3'(NUM_CLUSTERS))
                   && (6'(item_i.entry_index) < 6'(CLUSTER_LEVELS));
  assign c_waddr = CA_W'(int'(item_i.cluster_index) * CLUSTER_LEVELS
                         + int'(item_i.entry_index));
  assign g_we    = accept && (item_i.opcode == sft_pkg::OP_LOAD_GPU)
                   && (6'(item_i.entry_index) < 6'(GPU_LEVELS));

  // cluster table memory; writes only happen while idle, the read data register loads every clock
  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem_q[c_waddr] <= item_i.entry_freq;
    end
    c_rdata_q <= cmem_q[c_raddr];
  end

  // gpu table memory
  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem_q[item_i.entry_index[GA_W-1:0]] <= item_i.entry_freq;
    end
    g_rdata_q <= gmem_q[g_raddr];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    c_d         = c_q;
    lvl_d       = lvl_q;
    half_d      = half_q;
    fin_d       = fin_q;
    gok_d       = gok_q;
    level_d     = level_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    case (state_q)
      sft_pkg::S_IDLE: begin
        if (accept) begin
          res_d.destination = '0;
          res_d.new_limit   = '0;
          res_d.update      = 1'b0;
          res_d.step_count  = cnt_q;
          res_d.status      = sft_pkg::ST_DONE;
          res_d.last        = 1'b1;
          c_d               = '0;
          if (item_i.opcode == sft_pkg::OP_LOAD_CPU) begin
            res_valid_d       = 1'b1;
            res_d.destination = 3'(item_i.cluster_index);
            res_d.new_limit   = item_i.entry_freq;
            res_d.status      = sft_pkg::ST_LOADED;
          end else if (item_i.opcode == sft_pkg::OP_LOAD_GPU) begin
            res_valid_d       = 1'b1;
            res_d.destination = sft_pkg::GPU_DEST;
            res_d.new_limit   = item_i.entry_freq;
            res_d.status      = sft_pkg::ST_LOADED;
          end else if (!enable_q) begin
            res_valid_d  = 1'b1;
            res_d.status = sft_pkg::ST_NOINIT;
          end else if (item_i.opcode == sft_pkg::OP_WARN) begin
            cnt_d   = (cnt_q == sft_pkg::CNT_MAX) ? cnt_q : cnt_q + 8'd1;
            state_d = sft_pkg::S_CSEL;
          end else if (cnt_q == '0) begin
            res_valid_d       = 1'b1;
            res_d.destination = sft_pkg::GPU_DEST;
          end else begin
            cnt_d   = '0;
            state_d = sft_pkg::S_RREAD;
          end
        end
      end

      // pick the next unmasked cluster, level 0 read goes out
      sft_pkg::S_CSEL: begin
        lvl_d = SCN_W'(1);
        if (skip_q[c_q]) begin
          if (c_last) begin
            state_d = sft_pkg::S_GPU;
          end else begin
            c_d = c_q + CW'(1);
          end
        end else begin
          state_d = sft_pkg::S_HALF;
        end
      end

      // half of the top frequency, level 1 read goes out
      sft_pkg::S_HALF: begin
        half_d = c_rdata_q >> 1;
        if (top_lvl == '0) begin
          state_d = sft_pkg::S_ADD;
        end else begin
          state_d = sft_pkg::S_SCAN;
        end
      end

      // one level per cycle until at or below half, or past top
      sft_pkg::S_SCAN: begin
        if (half_q >= c_rdata_q) begin
          state_d = sft_pkg::S_ADD;
        end else begin
          lvl_d = lvl_q + SCN_W'(1);
          if (lvl_q == SCN_W'(top_lvl)) begin
            state_d = sft_pkg::S_ADD;
          end
        end
      end

      // add the step count and clamp, read the final level
      sft_pkg::S_ADD: begin
        fin_d   = fin;
        state_d = sft_pkg::S_CEMIT;
      end

      // report the cluster limit
      sft_pkg::S_CEMIT: begin
        res_valid_d       = 1'b1;
        res_d.destination = 3'(c_q);
        res_d.new_limit   = c_rdata_q;
        res_d.update      = (level_q[c_q] != fin_q);
        res_d.step_count  = cnt_q;
        res_d.status      = sft_pkg::ST_DONE;
        res_d.last        = 1'b0;
        level_d[c_q]      = fin_q;
        if (c_last) begin
          state_d = sft_pkg::S_GPU;
        end else begin
          c_d     = c_q + CW'(1);
          state_d = sft_pkg::S_CSEL;
        end
      end

      // gpu index check, gpu table read goes out
      sft_pkg::S_GPU: begin
        gok_d   = (gidx < GI_W'(gents));
        state_d = sft_pkg::S_GEMIT;
      end

      sft_pkg::S_GEMIT: begin
        res_valid_d       = 1'b1;
        res_d.destination = sft_pkg::GPU_DEST;
        res_d.new_limit   = gok_q ? g_rdata_q : '0;
        res_d.update      = gok_q;
        res_d.step_count  = cnt_q;
        res_d.status      = sft_pkg::ST_DONE;
        res_d.last        = 1'b1;
        state_d           = sft_pkg::S_IDLE;
      end

      // release: level 0 read of each cluster
      sft_pkg::S_RREAD: begin
        state_d = sft_pkg::S_REMIT;
      end

      sft_pkg::S_REMIT: begin
        res_valid_d       = 1'b1;
        res_d.destination = 3'(c_q);
        res_d.new_limit   = c_rdata_q;
        res_d.update      = (level_q[c_q] != '0);
        res_d.step_count  = cnt_q;
        res_d.status      = sft_pkg::ST_DONE;
        res_d.last        = 1'b0;
        level_d[c_q]      = '0;
        if (c_last) begin
          state_d = sft_pkg::S_RGPU;
        end else begin
          c_d     = c_q + CW'(1);
          state_d = sft_pkg::S_RREAD;
        end
      end

      sft_pkg::S_RGPU: begin
        res_valid_d       = 1'b1;
        res_d.destination = sft_pkg::GPU_DEST;
        res_d.new_limit   = grel_q;
        res_d.update      = 1'b1;
        res_d.step_count  = cnt_q;
        res_d.status      = sft_pkg::ST_DONE;
        res_d.last        = 1'b1;
        state_d           = sft_pkg::S_IDLE;
      end

      default: begin
        state_d = sft_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sft_pkg::S_IDLE;
      cnt_q       <= '0;
      c_q         <= '0;
      lvl_q       <= '0;
      gok_q       <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
        level_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      c_q         <= c_d;
      lvl_q       <= lvl_d;
      gok_q       <= gok_d;
      res_valid_q <= res_valid_d;
      level_q     <= level_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    half_q <= half_d;
    fin_q  <= fin_d;
    res_q  <= res_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      skip_q   <= 4'h1;
      tops_q   <= '0;
      gents_q  <= 6'd1;
      grel_q   <= '1;
    end else if (cfg_we) begin
      case (paddr[4:2])
        sft_pkg::REG_ENABLE:    enable_q <= pwdata[0];
        sft_pkg::REG_SKIP_MASK: skip_q   <= pwdata[3:0];
        sft_pkg::REG_TOP_LVLS:  tops_q   <= pwdata[19:0];
        sft_pkg::REG_GPU_ENTS:  gents_q  <= pwdata[5:0];
        sft_pkg::REG_GPU_REL:   grel_q   <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[4:2])
      sft_pkg::REG_ENABLE:    prdata = 32'(enable_q);
      sft_pkg::REG_SKIP_MASK: prdata = 32'(skip_q);
      sft_pkg::REG_TOP_LVLS:  prdata = 32'(tops_q);
      sft_pkg::REG_GPU_ENTS:  prdata = 32'(gents_q);
      sft_pkg::REG_GPU_REL:   prdata = 32'(grel_q);
      default:                prdata = '0;
    endcase
  end

  // the final item of a command leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("last item while sequencer busy");

  // the counter only moves when a command is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(cnt_q))
    else $error("step counter changed during a sequence");

  // a completed warning or release always ends on the gpu
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last && (res_o.status == sft_pkg::ST_DONE)
      |-> (res_o.destination == sft_pkg::GPU_DEST))
    else $error("sequence ended on a cluster item");

  // no item without a command taken or a sequence running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy) || $past(busy))
    else $error("item without a command");

endmodule

@@ verif/tb_stepwise_frequency_throttle_unit.sv @@
// self-checking testbench of the stepwise frequency throttle unit
`timescale 1ns / 1ps

module tb_stepwise_frequency_throttle_unit;

  localparam int NCL        = 4;
  localparam int CLVL       = 32;
  localparam int GLVL       = 32;
  localparam int QUIET_MAX  = 4000;
  localparam int DRAIN_TAIL = 16;
  localparam int END_TAIL   = 200;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // block inputs, known from time zero
  logic                start   = 1'b0;
  sft_pkg::sft_item_t  item_i  = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [4:0]          paddr   = '0;
  logic [31:0]         pwdata  = '0;

  // block outputs
  logic                 busy;
  logic                 res_valid_o;
  sft_pkg::sft_result_t res_o;
  logic [31:0]          prdata;
  logic                 pready;

  stepwise_frequency_throttle_unit #(
    .NUM_CLUSTERS  (NCL),
    .CLUSTER_LEVELS(CLVL),
    .GPU_LEVELS    (GLVL)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // pending commands and predicted limit updates
  sft_pkg::sft_item_t   cmd_q[$];
  sft_pkg::sft_result_t limit_updates_q[$];

  // shadow of the throttle state and registers
  logic [sft_pkg::CNT_W-1:0]  step_cnt;
  logic [4:0]                 clus_lvl [0:NCL-1];
  logic [sft_pkg::FREQ_W-1:0] cpu_tab  [0:4*CLVL-1];
  logic [sft_pkg::FREQ_W-1:0] gpu_tab  [0:GLVL-1];
  logic                       cfg_en;
  logic [3:0]                 cfg_skip;
  logic [19:0]                cfg_tops;
  logic [5:0]                 cfg_gents;
  logic [sft_pkg::FREQ_W-1:0] cfg_grel;

  // bookkeeping
  int   n_sent = 0;
  int   n_acc  = 0;
  int   n_res  = 0;
  int   n_err  = 0;
  int   n_warn = 0;
  int   n_rel  = 0;
  int   n_load = 0;
  int   n_wr   = 0;
  int   peak_cnt = 0;
  int   gap_pct = 27;
  int   quiet  = 0;
  logic took_q = 1'b0;

  initial begin
    step_cnt  = '0;
    for (int c = 0; c < NCL; c++) clus_lvl[c] = '0;
    cfg_en    = 1'b0;
    cfg_skip  = 4'h1;
    cfg_tops  = '0;
    cfg_gents = 6'd1;
    cfg_grel  = 24'hFFFFFF;
  end

  // one result with the current step count
  function automatic sft_pkg::sft_result_t limit_result(logic [2:0] dest,
                                                        logic [sft_pkg::FREQ_W-1:0] lim,
                                                        logic upd, logic [1:0] st);
    sft_pkg::sft_result_t r;
    r             = '0;
    r.destination = dest;
    r.new_limit   = lim;
    r.update      = upd;
    r.step_count  = step_cnt;
    r.status      = st;
    return r;
  endfunction

  // predicted limit updates of one accepted item
  function automatic void throttle_step(sft_pkg::sft_item_t it);
    sft_pkg::sft_result_t       outs [0:4];
    sft_pkg::sft_result_t       r;
    int                         n;
    int                         top;
    int                         lvl;
    int                         ents;
    int                         gidx;
    logic [sft_pkg::FREQ_W-1:0] half;
    n = 0;
    if (it.opcode == sft_pkg::OP_LOAD_CPU) begin
      n_load++;
      cpu_tab[{it.cluster_index, it.entry_index}] = it.entry_freq;
      outs[n] = limit_result({1'b0, it.cluster_index}, it.entry_freq, 1'b0,
                             sft_pkg::ST_LOADED);
      n++;
    end else if (it.opcode == sft_pkg::OP_LOAD_GPU) begin
      n_load++;
      gpu_tab[it.entry_index] = it.entry_freq;
      outs[n] = limit_result(sft_pkg::GPU_DEST, it.entry_freq, 1'b0, sft_pkg::ST_LOADED);
      n++;
    end else if (!cfg_en) begin
      if (it.opcode == sft_pkg::OP_WARN) n_warn++;
      else n_rel++;
      outs[n] = limit_result(3'd0, '0, 1'b0, sft_pkg::ST_NOINIT);
      n++;
    end else if (it.opcode == sft_pkg::OP_WARN) begin
      n_warn++;
      if (step_cnt != sft_pkg::CNT_MAX) step_cnt++;
      if (int'(step_cnt) > peak_cnt) peak_cnt = int'(step_cnt);
      for (int c = 0; c < NCL; c++) begin
        if (!cfg_skip[c]) begin
          top  = int'(cfg_tops[5*c +: 5]);
          half = cpu_tab[c*CLVL] >> 1;
          // first level at or below half of the top frequency
          lvl  = 1;
          while (lvl <= top && half < cpu_tab[c*CLVL + lvl]) lvl++;
          lvl = lvl + int'(step_cnt);
          if (lvl > top) lvl = top;
          outs[n] = limit_result(3'(c), cpu_tab[c*CLVL + lvl], int'(clus_lvl[c]) != lvl,
                                 sft_pkg::ST_DONE);
          clus_lvl[c] = 5'(lvl);
          n++;
        end
      end
      // gpu level from the middle of its table
      ents = (int'(cfg_gents) > GLVL) ? GLVL : int'(cfg_gents);
      gidx = ents / 2 + int'(step_cnt);
      if (gidx < ents) begin
        outs[n] = limit_result(sft_pkg::GPU_DEST, gpu_tab[gidx], 1'b1, sft_pkg::ST_DONE);
      end else begin
        outs[n] = limit_result(sft_pkg::GPU_DEST, '0, 1'b0, sft_pkg::ST_DONE);
      end
      n++;
    end else begin
      n_rel++;
      if (step_cnt == '0) begin
        outs[n] = limit_result(sft_pkg::GPU_DEST, '0, 1'b0, sft_pkg::ST_DONE);
        n++;
      end else begin
        step_cnt = '0;
        for (int c = 0; c < NCL; c++) begin
          outs[n] = limit_result(3'(c), cpu_tab[c*CLVL], clus_lvl[c] != '0,
                                 sft_pkg::ST_DONE);
          clus_lvl[c] = '0;
          n++;
        end
        outs[n] = limit_result(sft_pkg::GPU_DEST, cfg_grel, 1'b1, sft_pkg::ST_DONE);
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      r      = outs[k];
      r.last = (k == n - 1);
      limit_updates_q.push_back(r);
    end
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  // command driver, changes at the falling edge
  always @(negedge clk_i) begin : cmd_driver
    if (start && !took_q) begin
      // item still waiting for the block
    end else if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
      item_i <= cmd_q.pop_front();
      start  <= 1'b1;
    end else begin
      start  <= 1'b0;
    end
  end

  // result monitor, acceptance and watchdog at the rising edge
  always @(posedge clk_i) begin : res_monitor
    sft_pkg::sft_result_t want;
    if (rst_ni) begin
      took_q = start && !busy;
      if (res_valid_o) begin
        n_res++;
        if (limit_updates_q.size() == 0) begin
          $error("result with no item outstanding: %0h", res_o);
          n_err++;
        end else begin
          want = limit_updates_q.pop_front();
          check_field("destination", 32'(want.destination), 32'(res_o.destination));
          check_field("new_limit", 32'(want.new_limit), 32'(res_o.new_limit));
          check_field("update", 32'(want.update), 32'(res_o.update));
          check_field("step_count", 32'(want.step_count), 32'(res_o.step_count));
          check_field("status", 32'(want.status), 32'(res_o.status));
          check_field("last", 32'(want.last), 32'(res_o.last));
        end
      end
      if (took_q === 1'b1) begin
        throttle_step(item_i);
        n_acc++;
      end
      if (took_q === 1'b1 || res_valid_o === 1'b1 || psel) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("timeout: %0d items outstanding", n_sent - n_acc);
        $display("tb_stepwise_frequency_throttle_unit: errors");
        $finish;
      end
    end else begin
      took_q = 1'b0;
    end
  end

  task automatic queue_cmd(logic [1:0] op, logic [1:0] ci, logic [4:0] ei,
                           logic [sft_pkg::FREQ_W-1:0] fq);
    sft_pkg::sft_item_t it;
    it.opcode        = op;
    it.cluster_index = ci;
    it.entry_index   = ei;
    it.entry_freq    = fq;
    cmd_q.push_back(it);
    n_sent++;
  endtask

  // event item with random don't-care fields
  task automatic queue_event(logic [1:0] op);
    queue_cmd(op, 2'($urandom), 5'($urandom), 24'($urandom));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || n_acc != n_sent || limit_updates_q.size() != 0);
    repeat (DRAIN_TAIL) @(negedge clk_i);
  endtask

  // apb write then read back
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] got;
    case (idx)
      sft_pkg::REG_ENABLE:    mask = 32'h1;
      sft_pkg::REG_SKIP_MASK: mask = 32'hF;
      sft_pkg::REG_TOP_LVLS:  mask = 32'hFFFFF;
      sft_pkg::REG_GPU_ENTS:  mask = 32'h3F;
      default:                mask = 32'hFFFFFF;
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= (val & mask) | ($urandom & ~mask);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("prdata", val & mask, got);
    case (idx)
      sft_pkg::REG_ENABLE:    cfg_en    = val[0];
      sft_pkg::REG_SKIP_MASK: cfg_skip  = val[3:0];
      sft_pkg::REG_TOP_LVLS:  cfg_tops  = val[19:0];
      sft_pkg::REG_GPU_ENTS:  cfg_gents = val[5:0];
      default:                cfg_grel  = val[23:0];
    endcase
    n_wr++;
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned f;
    int unsigned f0;
    int unsigned dec;
    int          r;
    int          k;
    int          cnt;
    logic [5:0]  gents_pick [0:5];
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // events before the block is enabled
    queue_event(sft_pkg::OP_WARN);
    queue_event(sft_pkg::OP_RELEASE);

    // fill every table entry: sloped, flat, cliff and random cluster shapes
    f0 = $urandom_range(16000000, 8000000);
    f  = f0;
    for (int c = 0; c < NCL; c++) begin
      for (int e = 0; e < CLVL; e++) begin
        case (c)
          0: begin
            dec = $urandom_range(f0 / 16);
            if (e != 0) f = (dec > f) ? 0 : f - dec;
          end
          1: f = 24'hFFFFFF;
          2: f = (e == 0) ? 24'hFFFFFF : (e == 1) ? 0 : $urandom_range(1000);
          default: f = $urandom & 24'hFFFFFF;
        endcase
        queue_cmd(sft_pkg::OP_LOAD_CPU, 2'(c), 5'(e), 24'(f));
      end
    end
    f = 24'hFFFFFF;
    for (int e = 0; e < GLVL; e++) begin
      dec = $urandom_range(500000);
      if (e != 0) f = (dec > f) ? 0 : f - dec;
      queue_cmd(sft_pkg::OP_LOAD_GPU, 2'($urandom), 5'(e), 24'(f));
    end
    wait_idle();

    // all clusters active at their deepest top level
    write_reg(sft_pkg::REG_ENABLE, 32'd1);
    write_reg(sft_pkg::REG_SKIP_MASK, 32'h0);
    write_reg(sft_pkg::REG_TOP_LVLS, 32'hFFFFF);
    write_reg(sft_pkg::REG_GPU_ENTS, 32'd32);
    write_reg(sft_pkg::REG_GPU_REL, $urandom);
    queue_event(sft_pkg::OP_RELEASE);
    repeat (3) queue_event(sft_pkg::OP_WARN);
    queue_event(sft_pkg::OP_RELEASE);
    queue_event(sft_pkg::OP_WARN);
    queue_event(sft_pkg::OP_RELEASE);
    wait_idle();

    // drive the counter into saturation with every cluster masked
    write_reg(sft_pkg::REG_SKIP_MASK, 32'hF);
    write_reg(sft_pkg::REG_GPU_ENTS, 32'h3F);
    repeat (258) queue_event(sft_pkg::OP_WARN);
    wait_idle();

    // saturated counter against empty gpu range and zero top levels
    write_reg(sft_pkg::REG_SKIP_MASK, 32'h0);
    write_reg(sft_pkg::REG_TOP_LVLS, 32'h0);
    write_reg(sft_pkg::REG_GPU_ENTS, 32'h0);
    write_reg(sft_pkg::REG_GPU_REL, 32'h0);
    repeat (2) queue_event(sft_pkg::OP_WARN);
    queue_event(sft_pkg::OP_RELEASE);
    queue_event(sft_pkg::OP_WARN);
    queue_event(sft_pkg::OP_RELEASE);
    wait_idle();

    // random settings, mostly warning bursts closed by a release
    gents_pick[0] = 6'd32;
    gents_pick[1] = 6'd1;
    gents_pick[2] = 6'd63;
    gents_pick[3] = 6'd0;
    gents_pick[4] = 6'd2;
    gents_pick[5] = 6'($urandom);
    for (int s = 0; s < 6; s++) begin
      write_reg(sft_pkg::REG_ENABLE, (s == 3) ? 32'd0 : 32'd1);
      write_reg(sft_pkg::REG_SKIP_MASK, (s == 0) ? 32'h0 : (s == 1) ? 32'hF : $urandom);
      write_reg(sft_pkg::REG_TOP_LVLS, (s == 0) ? 32'hFFFFF : (s == 1) ? 32'h0 : $urandom);
      write_reg(sft_pkg::REG_GPU_ENTS, 32'(gents_pick[s]));
      write_reg(sft_pkg::REG_GPU_REL, (s == 0) ? 32'hFFFFFF : (s == 1) ? 32'h0 : $urandom);
      gap_pct = (s == 2) ? 0 : 27;
      cnt = 0;
      while (cnt < 12) begin
        r = $urandom_range(99);
        if (r < 55) begin
          k = $urandom_range(6, 1);
          repeat (k) queue_event(sft_pkg::OP_WARN);
          cnt += k;
          if ($urandom_range(4) != 0) begin
            queue_event(sft_pkg::OP_RELEASE);
            cnt++;
          end
        end else if (r < 80) begin
          queue_cmd($urandom_range(1) ? sft_pkg::OP_LOAD_CPU : sft_pkg::OP_LOAD_GPU,
                    2'($urandom), 5'($urandom), 24'($urandom));
          cnt++;
        end else begin
          queue_cmd(2'($urandom), 2'($urandom), 5'($urandom), 24'($urandom));
          cnt++;
        end
      end
      wait_idle();
    end
    gap_pct = 27;

    // let any stray result show up
    repeat (END_TAIL) @(negedge clk_i);

    $display("covered %0d items: %0d warnings, %0d releases, %0d table loads",
             n_acc, n_warn, n_rel, n_load);
    $display("checked %0d results over %0d register writes, step count peak %0d",
             n_res, n_wr, peak_cnt);
    if (n_err == 0) begin
      $display("tb_stepwise_frequency_throttle_unit: clean");
    end else begin
      $display("tb_stepwise_frequency_throttle_unit: errors");
    end
    $finish;
  end

endmodule
